// ===== src/gclp_pkg.sv =====
// gclp_pkg: shared types, constants and helper functions of the g-code line parser
// used by every module of the block
package gclp_pkg;

    localparam int CHAR_W   = 8;
    localparam int MANT_W   = 26;
    localparam int DEC_W    = 3;
    localparam int EXP_W    = 2;
    localparam int SEEN_W   = 12;
    localparam int MASK_W   = 13;
    localparam int VAL_W    = 32;
    localparam int BYTE_W   = 8;
    localparam int MULT_W   = 17;
    localparam int RECIP_W  = 27;
    localparam int SHIFT_W  = 6;
    localparam int POW_W    = 10;
    localparam int REM_W    = 10;
    localparam int TEN_W    = MANT_W + POW_W;
    localparam int PROD1_W  = MANT_W + RECIP_W;
    localparam int QM_W     = MANT_W + MULT_W;
    localparam int T_W      = 27;
    localparam int PROD2_W  = T_W + RECIP_W;
    localparam int MAG_W    = QM_W + 1;
    localparam int CK_BIT   = 11;

    localparam logic [MANT_W-1:0] MANTISSA_LIMIT = 26'd4289967;
    localparam logic [DEC_W-1:0]  MAX_DECIMALS   = 3'd3;
    localparam logic [MULT_W-1:0] PID_FACTOR     = 17'd1024;
    localparam logic [MULT_W-1:0] HEAT_FACTOR    = 17'd4;
    localparam logic [MULT_W-1:0] UNIT_FACTOR    = 17'd1;

    localparam logic [BYTE_W-1:0] M_HOTEND_SET  = 8'd104;
    localparam logic [BYTE_W-1:0] M_HOTEND_WAIT = 8'd109;
    localparam logic [BYTE_W-1:0] M_BED_SET     = 8'd140;
    localparam logic [BYTE_W-1:0] M_PID_LO      = 8'd130;
    localparam logic [BYTE_W-1:0] M_PID_HI      = 8'd132;

    typedef enum logic [3:0] {
        W_G, W_M, W_X, W_Y, W_Z, W_E, W_F, W_S, W_P, W_T, W_N, W_CK, W_NONE
    } word_t;

    typedef struct packed {
        logic                 eol;
        word_t                word;
        logic                 neg;
        logic [MANT_W-1:0]    mant;
        logic [EXP_W-1:0]     expo;
        logic [SEEN_W-1:0]    mask;
        logic [BYTE_W-1:0]    csum;
    } job_t;

    typedef struct packed {
        logic                 eol;
        word_t                word;
        logic                 neg;
        logic [MAG_W-1:0]     mag;
        logic [BYTE_W-1:0]    intv;
        logic [SEEN_W-1:0]    mask;
        logic [BYTE_W-1:0]    csum;
    } res_t;

    typedef struct packed {
        logic [MASK_W-1:0]    seen_mask;
        logic [BYTE_W-1:0]    g_number;
        logic [BYTE_W-1:0]    m_number;
        logic [VAL_W-1:0]     pos_x;
        logic [VAL_W-1:0]     pos_y;
        logic [VAL_W-1:0]     pos_z;
        logic [VAL_W-1:0]     pos_e;
        logic [VAL_W-1:0]     feed_rate;
        logic [VAL_W-1:0]     s_value;
        logic [VAL_W-1:0]     p_value;
        logic [BYTE_W-1:0]    tool_number;
        logic [VAL_W-1:0]     line_number;
    } out_t;

    function automatic word_t word_of(input logic [CHAR_W-1:0] c);
        word_t w;
        case (c)
            8'h47:   w = W_G;
            8'h4D:   w = W_M;
            8'h58:   w = W_X;
            8'h59:   w = W_Y;
            8'h5A:   w = W_Z;
            8'h45:   w = W_E;
            8'h46:   w = W_F;
            8'h53:   w = W_S;
            8'h50:   w = W_P;
            8'h54:   w = W_T;
            8'h4E:   w = W_N;
            8'h2A:   w = W_CK;
            default: w = W_NONE;
        endcase
        return w;
    endfunction

    // reciprocal of 10^e, exact for operands below 2^27
    function automatic logic [RECIP_W-1:0] recip(input logic [EXP_W-1:0] e);
        logic [RECIP_W-1:0] r;
        case (e)
            2'd1:    r = 27'd107374183;
            2'd2:    r = 27'd85899346;
            2'd3:    r = 27'd68719477;
            default: r = 27'd1;
        endcase
        return r;
    endfunction

    function automatic logic [SHIFT_W-1:0] rshift(input logic [EXP_W-1:0] e);
        logic [SHIFT_W-1:0] s;
        case (e)
            2'd1:    s = 6'd30;
            2'd2:    s = 6'd33;
            2'd3:    s = 6'd36;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [EXP_W-1:0] e);
        logic [POW_W-1:0] p;
        case (e)
            2'd1:    p = 10'd10;
            2'd2:    p = 10'd100;
            2'd3:    p = 10'd1000;
            default: p = 10'd1;
        endcase
        return p;
    endfunction

    function automatic logic [POW_W-1:0] half10(input logic [EXP_W-1:0] e);
        logic [POW_W-1:0] h;
        case (e)
            2'd1:    h = 10'd5;
            2'd2:    h = 10'd50;
            2'd3:    h = 10'd500;
            default: h = 10'd0;
        endcase
        return h;
    endfunction

    // times 1000 with the decimal digits folded in
    function automatic logic [POW_W-1:0] milli_mult(input logic [EXP_W-1:0] e);
        logic [POW_W-1:0] p;
        case (e)
            2'd1:    p = 10'd100;
            2'd2:    p = 10'd10;
            2'd3:    p = 10'd1;
            default: p = 10'd1000;
        endcase
        return p;
    endfunction

endpackage

// ===== src/gclp_parse.sv =====
// gclp_parse: character front end, word and comment tracking, checksum xor
// emits one conversion job per closed word or line end; uses gclp_pkg
module gclp_parse (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic                        advance,
    input  logic [gclp_pkg::CHAR_W-1:0] char_code,
    output logic                        job_valid,
    output gclp_pkg::job_t              job
);
    import gclp_pkg::*;

    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'd32;

    logic [CHAR_W-1:0] pending_reg, pending_next;
    logic              neg_reg, neg_next;
    logic [MANT_W-1:0] mant_reg, mant_next;
    logic [DEC_W-1:0]  dec_reg, dec_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [BYTE_W-1:0] csum_reg, csum_next;
    logic              lcom_reg, lcom_next;
    logic              pcom_reg, pcom_next;
    logic              job_valid_reg;
    job_t              job_reg, job_next;

    logic [CHAR_W-1:0] c;
    logic              is_letter, is_star, is_eol, close;
    word_t             w;
    logic [29:0]       acc;
    logic [CHAR_W-1:0] digit;

    always_comb begin
        c = char_code;
        if (char_code >= CH_LA && char_code <= CH_LZ) begin
            c = char_code - CASE_OFS;
        end
        is_letter = (c >= CH_UA && c <= CH_UZ);
        is_star   = (c == CH_STAR);
        is_eol    = (c == CH_LF || c == CH_CR);
        close     = (pending_reg != '0) && (is_letter || is_star || is_eol);
        w         = word_of(c);
        digit     = c - CH_0;
        acc       = 30'd0;

        pending_next = pending_reg;
        neg_next     = neg_reg;
        mant_next    = mant_reg;
        dec_next     = dec_reg;
        seen_next    = seen_reg;
        csum_next    = csum_reg;
        lcom_next    = lcom_reg;
        pcom_next    = pcom_reg;

        job_next.eol  = is_eol;
        job_next.word = close ? word_of(pending_reg) : W_NONE;
        job_next.neg  = neg_reg;
        job_next.mant = mant_reg;
        job_next.expo = (dec_reg == '0) ? '0 : EXP_W'(dec_reg - 3'd1);

        if (close) begin
            pending_next = '0;
            neg_next     = 1'b0;
            mant_next    = '0;
            dec_next     = '0;
        end

        if (!lcom_reg && !pcom_reg) begin
            if (is_letter || is_star) begin
                pending_next = c;
            end
            if (w != W_NONE) begin
                seen_next = seen_next | (SEEN_W'(1) << w);
                if (w == W_G) begin
                    seen_next[W_M] = 1'b0;
                end else if (w == W_M) begin
                    seen_next[W_G] = 1'b0;
                end
            end else if (c == CH_SEMI) begin
                lcom_next = 1'b1;
            end else if (c == CH_OPEN) begin
                pcom_next = 1'b1;
            end else if (c == CH_MINUS) begin
                neg_next  = 1'b1;
                mant_next = '0;
                dec_next  = '0;
            end else if (c == CH_POINT) begin
                if (dec_next == '0) begin
                    dec_next = 3'd1;
                end
            end else if (c >= CH_0 && c <= CH_9) begin
                if (dec_next <= MAX_DECIMALS && mant_next < MANTISSA_LIMIT) begin
                    acc       = {4'b0, mant_next} * 30'd10 + {26'b0, digit[3:0]};
                    mant_next = acc[MANT_W-1:0];
                    if (dec_next != '0) begin
                        dec_next = dec_next + 3'd1;
                    end
                end
            end
        end else if (pcom_reg && c == CH_CLOSE) begin
            pcom_next = 1'b0;
        end

        if (!seen_next[CK_BIT]) begin
            csum_next = csum_reg ^ char_code;
        end

        job_next.mask = seen_next;
        job_next.csum = csum_next;

        if (is_eol) begin
            seen_next = SEEN_W'(1);
            lcom_next = 1'b0;
            pcom_next = 1'b0;
            csum_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= '0;
            neg_reg       <= 1'b0;
            mant_reg      <= '0;
            dec_reg       <= '0;
            seen_reg      <= SEEN_W'(1);
            csum_reg      <= '0;
            lcom_reg      <= 1'b0;
            pcom_reg      <= 1'b0;
            job_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                pending_reg <= pending_next;
                neg_reg     <= neg_next;
                mant_reg    <= mant_next;
                dec_reg     <= dec_next;
                seen_reg    <= seen_next;
                csum_reg    <= csum_next;
                lcom_reg    <= lcom_next;
                pcom_reg    <= pcom_next;
            end
            if (advance) begin
                job_valid_reg <= accept && (close || is_eol);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

// ===== src/gclp_scale.sv =====
// gclp_scale: four-stage number conversion pipeline (divide by 10^e, scale, round)
// turns a closed word into its magnitude and integer part; uses gclp_pkg
module gclp_scale (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  logic           job_valid,
    input  gclp_pkg::job_t job,
    output logic           res_valid,
    output gclp_pkg::res_t res
);
    import gclp_pkg::*;

    logic               v2_reg, v3_reg, v4_reg, v5_reg;
    job_t               j2_reg, j3_reg, j4_reg, j5_reg;
    logic [PROD1_W-1:0] prod1_reg, prod1_next;
    logic [TEN_W-1:0]   tp2_reg, tp3_reg, tp4_reg, tp5_reg, tp_next;
    logic [MANT_W-1:0]  q0_reg, q0_next;
    logic [BYTE_W-1:0]  i4_reg, i5_reg;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [BYTE_W-1:0]  mfast_reg;
    logic [QM_W-1:0]    qm4_reg, qm5_reg, qm_next;
    logic [T_W-1:0]     t_reg, t_next;
    logic [PROD2_W-1:0] prod2_reg, prod2_next;
    logic [PROD1_W-1:0] sh1;
    logic [TEN_W-1:0]   qd;
    logic [MULT_W-1:0]  mult;
    logic [PROD2_W-1:0] sh2;
    logic [T_W-1:0]     q1;
    logic               ten;

    always_comb begin
        prod1_next = {27'b0, job.mant} * {26'b0, recip(job.expo)};
        tp_next    = {10'b0, job.mant} * {26'b0, milli_mult(job.expo)};
    end

    always_comb begin
        sh1      = prod1_reg >> rshift(j2_reg.expo);
        q0_next  = (j2_reg.expo == '0) ? j2_reg.mant : sh1[MANT_W-1:0];
        qd       = {10'b0, q0_next} * {26'b0, pow10(j2_reg.expo)};
        rem_next = REM_W'(j2_reg.mant - qd[MANT_W-1:0]);
    end

    always_comb begin
        mult = UNIT_FACTOR;
        if (j3_reg.word == W_S) begin
            if (mfast_reg == M_HOTEND_SET || mfast_reg == M_HOTEND_WAIT
                || mfast_reg == M_BED_SET) begin
                mult = HEAT_FACTOR;
            end else if (mfast_reg >= M_PID_LO && mfast_reg <= M_PID_HI) begin
                mult = PID_FACTOR;
            end
        end
        qm_next = {17'b0, q0_reg} * {26'b0, mult};
        t_next  = T_W'({17'b0, rem_reg} * {10'b0, mult}) + {17'b0, half10(j3_reg.expo)};
    end

    always_comb begin
        prod2_next = {27'b0, t_reg} * {27'b0, recip(j4_reg.expo)};
    end

    always_comb begin
        sh2 = prod2_reg >> rshift(j5_reg.expo);
        q1  = (j5_reg.expo == '0) ? '0 : sh2[T_W-1:0];
        ten = (j5_reg.word == W_X || j5_reg.word == W_Y || j5_reg.word == W_Z
               || j5_reg.word == W_E || j5_reg.word == W_F);
        res.eol  = j5_reg.eol;
        res.word = j5_reg.word;
        res.neg  = j5_reg.neg;
        res.mag  = ten ? {8'b0, tp5_reg} : ({1'b0, qm5_reg} + {17'b0, q1});
        res.intv = i5_reg;
        res.mask = j5_reg.mask;
        res.csum = j5_reg.csum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            mfast_reg <= '0;
        end else if (advance) begin
            v2_reg <= job_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (v2_reg && j2_reg.word == W_M) begin
                mfast_reg <= q0_next[BYTE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            j2_reg    <= job;
            prod1_reg <= prod1_next;
            tp2_reg   <= tp_next;
            j3_reg    <= j2_reg;
            q0_reg    <= q0_next;
            rem_reg   <= rem_next;
            tp3_reg   <= tp2_reg;
            j4_reg    <= j3_reg;
            qm4_reg   <= qm_next;
            t_reg     <= t_next;
            i4_reg    <= q0_reg[BYTE_W-1:0];
            tp4_reg   <= tp3_reg;
            j5_reg    <= j4_reg;
            prod2_reg <= prod2_next;
            qm5_reg   <= qm4_reg;
            i5_reg    <= i4_reg;
            tp5_reg   <= tp4_reg;
        end
    end

    assign res_valid = v5_reg;

endmodule

// ===== src/gclp_hold.sv =====
// gclp_hold: held word values, line-end snapshot and result register
// saturates converted magnitudes and applies line-end clearing; uses gclp_pkg
module gclp_hold (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  logic           res_valid,
    input  gclp_pkg::res_t res,
    input  logic           relative_xyz,
    input  logic           relative_e,
    output logic           out_valid,
    output gclp_pkg::out_t out_item
);
    import gclp_pkg::*;

    logic [BYTE_W-1:0] g_reg, m_reg, tool_reg;
    logic [VAL_W-1:0]  x_reg, y_reg, z_reg, e_reg, f_reg, s_reg, p_reg, line_reg, rc_reg;
    logic [BYTE_W-1:0] g_mid, m_mid, tool_mid;
    logic [VAL_W-1:0]  x_mid, y_mid, z_mid, e_mid, f_mid, s_mid, p_mid, line_mid, rc_mid;
    logic [VAL_W-1:0]  val;
    logic              fire, mismatch;
    logic              out_valid_reg;
    out_t              out_reg, out_next;

    always_comb begin
        if (res.neg) begin
            val = (res.mag > MAG_W'(32'h8000_0000)) ? 32'h8000_0000 : res.mag[VAL_W-1:0];
            val = VAL_W'(0) - val;
        end else begin
            val = (res.mag > MAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : res.mag[VAL_W-1:0];
        end
    end

    always_comb begin
        fire     = res_valid && advance;
        g_mid    = g_reg;
        m_mid    = m_reg;
        tool_mid = tool_reg;
        x_mid    = x_reg;
        y_mid    = y_reg;
        z_mid    = z_reg;
        e_mid    = e_reg;
        f_mid    = f_reg;
        s_mid    = s_reg;
        p_mid    = p_reg;
        line_mid = line_reg;
        rc_mid   = rc_reg;
        case (res.word)
            W_G:     g_mid    = res.intv;
            W_M:     m_mid    = res.intv;
            W_T:     tool_mid = res.intv;
            W_X:     x_mid    = val;
            W_Y:     y_mid    = val;
            W_Z:     z_mid    = val;
            W_E:     e_mid    = val;
            W_F:     f_mid    = val;
            W_S:     s_mid    = val;
            W_P:     p_mid    = val;
            W_N:     line_mid = val;
            W_CK:    rc_mid   = val;
            default: ;
        endcase
        mismatch = res.mask[CK_BIT] && (rc_mid != {24'b0, res.csum});
        out_next.seen_mask   = {mismatch, res.mask};
        out_next.g_number    = g_mid;
        out_next.m_number    = m_mid;
        out_next.pos_x       = x_mid;
        out_next.pos_y       = y_mid;
        out_next.pos_z       = z_mid;
        out_next.pos_e       = e_mid;
        out_next.feed_rate   = f_mid;
        out_next.s_value     = s_mid;
        out_next.p_value     = p_mid;
        out_next.tool_number = tool_mid;
        out_next.line_number = line_mid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_reg         <= BYTE_W'(1);
            m_reg         <= '0;
            tool_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            e_reg         <= '0;
            f_reg         <= '0;
            s_reg         <= '0;
            p_reg         <= '0;
            line_reg      <= '0;
            rc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= res_valid && res.eol;
            end
            if (fire) begin
                g_reg    <= res.eol ? BYTE_W'(1) : g_mid;
                m_reg    <= m_mid;
                tool_reg <= tool_mid;
                x_reg    <= (res.eol && relative_xyz) ? '0 : x_mid;
                y_reg    <= (res.eol && relative_xyz) ? '0 : y_mid;
                z_reg    <= (res.eol && relative_xyz) ? '0 : z_mid;
                e_reg    <= (res.eol && (relative_xyz || relative_e)) ? '0 : e_mid;
                f_reg    <= f_mid;
                s_reg    <= s_mid;
                p_reg    <= p_mid;
                line_reg <= line_mid;
                rc_reg   <= res.eol ? '0 : rc_mid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res.eol) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== src/gcode_line_parser_top.sv =====
// Character-serial g-code line parser. One character is taken per clock cycle,
// back to back unless a finished item waits on m_ready; one command item comes
// out for every CR or LF, through the parse job register, the number conversion
// pipeline (a reciprocal multiply, a remainder, a scale and a rounding multiply)
// and result register; the whole pipeline holds while an item waits on m_ready.
// Registers: relative_xyz at byte address 0, relative_e at 4, bit 0 of each.
// gcode_line_parser_top: apb register port, handshake control, submodule wiring
// depends on gclp_pkg, gclp_parse, gclp_scale, gclp_hold
module gcode_line_parser_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gclp_pkg::CHAR_W-1:0]  s_char_code,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gclp_pkg::MASK_W-1:0]  m_seen_mask,
    output logic [gclp_pkg::BYTE_W-1:0]  m_g_number,
    output logic [gclp_pkg::BYTE_W-1:0]  m_m_number,
    output logic signed [gclp_pkg::VAL_W-1:0] m_pos_x,
    output logic signed [gclp_pkg::VAL_W-1:0] m_pos_y,
    output logic signed [gclp_pkg::VAL_W-1:0] m_pos_z,
    output logic signed [gclp_pkg::VAL_W-1:0] m_pos_e,
    output logic signed [gclp_pkg::VAL_W-1:0] m_feed_rate,
    output logic signed [gclp_pkg::VAL_W-1:0] m_s_value,
    output logic signed [gclp_pkg::VAL_W-1:0] m_p_value,
    output logic [gclp_pkg::BYTE_W-1:0]  m_tool_number,
    output logic signed [gclp_pkg::VAL_W-1:0] m_line_number
);
    import gclp_pkg::*;

    localparam logic REG_RELATIVE_XYZ = 1'b0;
    localparam logic REG_RELATIVE_E   = 1'b1;

    logic relative_xyz_reg, relative_e_reg;
    logic advance, accept;
    logic job_valid, res_valid, out_valid;
    job_t job;
    res_t res;
    out_t out_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relative_xyz_reg <= 1'b0;
            relative_e_reg   <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_RELATIVE_XYZ: relative_xyz_reg <= pwdata[0];
                REG_RELATIVE_E:   relative_e_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_RELATIVE_E) ? {31'b0, relative_e_reg}
                                                 : {31'b0, relative_xyz_reg};
    assign pready = 1'b1;

    assign advance = !out_valid || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    gclp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .advance   (advance),
        .char_code (s_char_code),
        .job_valid (job_valid),
        .job       (job)
    );

    gclp_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .job_valid (job_valid),
        .job       (job),
        .res_valid (res_valid),
        .res       (res)
    );

    gclp_hold u_hold (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .res_valid    (res_valid),
        .res          (res),
        .relative_xyz (relative_xyz_reg),
        .relative_e   (relative_e_reg),
        .out_valid    (out_valid),
        .out_item     (out_item)
    );

    assign m_valid       = out_valid;
    assign m_seen_mask   = out_item.seen_mask;
    assign m_g_number    = out_item.g_number;
    assign m_m_number    = out_item.m_number;
    assign m_pos_x       = out_item.pos_x;
    assign m_pos_y       = out_item.pos_y;
    assign m_pos_z       = out_item.pos_z;
    assign m_pos_e       = out_item.pos_e;
    assign m_feed_rate   = out_item.feed_rate;
    assign m_s_value     = out_item.s_value;
    assign m_p_value     = out_item.p_value;
    assign m_tool_number = out_item.tool_number;
    assign m_line_number = out_item.line_number;

endmodule

// ===== tb/sv/gcode_line_parser_top_tb.sv =====
// gcode_line_parser_top_tb: self-checking testbench of the g-code line parser
// sends directed and random command text, predicts each command item, checks every field
// depends on gclp_pkg and gcode_line_parser_top
`timescale 1ns / 100ps

module gcode_line_parser_top_tb;
    import gclp_pkg::*;

    localparam int IDLE_WAIT  = 12;
    localparam int STALL_LEN  = 300;
    localparam int WDOG_LIMIT = 5000;
    localparam int ITEM_GOAL  = 1950;
    localparam logic [2:0] ADDR_REL_XYZ = 3'd0;
    localparam logic [2:0] ADDR_REL_E   = 3'd4;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CHAR_W-1:0] s_char_code = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t got;

    gcode_line_parser_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_char_code(s_char_code),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_seen_mask(got.seen_mask), .m_g_number(got.g_number),
        .m_m_number(got.m_number), .m_pos_x(got.pos_x), .m_pos_y(got.pos_y),
        .m_pos_z(got.pos_z), .m_pos_e(got.pos_e), .m_feed_rate(got.feed_rate),
        .m_s_value(got.s_value), .m_p_value(got.p_value),
        .m_tool_number(got.tool_number), .m_line_number(got.line_number)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // parser model state
    logic        rel_xyz, rel_e;
    logic [7:0]  open_letter;
    logic        num_neg;
    logic [25:0] num_mant;
    logic [2:0]  num_dec;
    logic [7:0]  cur_g, cur_m, cur_tool;
    logic [31:0] cur_axis [4];
    logic [31:0] cur_feed, cur_s, cur_p, cur_line, rx_sum;
    logic [7:0]  calc_sum;
    logic [11:0] seen;
    logic        in_semi, in_paren;

    out_t pending_cmds[$];
    int   errors = 0;
    int   sent = 0;
    bit   quiet = 0;
    bit   long_hold = 0;
    int   idle_cycles = 0;

    function automatic logic [31:0] scaled(input int unsigned mult_in);
        logic [63:0] r, p;
        int e;
        int unsigned mult;
        mult = mult_in;
        r = num_mant;
        e = num_dec;
        if (e > 0) e--;
        while (e > 0 && mult % 10 == 0) begin
            mult = mult / 10;
            e--;
        end
        r = r * mult;
        if (e > 0) begin
            p = 10 ** e;
            r = (r + p / 2) / p;
        end
        if (num_neg) begin
            if (r > 64'h8000_0000) r = 64'h8000_0000;
            return 32'd0 - r[31:0];
        end
        if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
        return r[31:0];
    endfunction

    function automatic logic [7:0] whole_part();
        int e;
        logic [63:0] q;
        e = num_dec;
        if (e > 0) e--;
        q = num_mant / (10 ** e);
        return q[7:0];
    endfunction

    function automatic int letter_index(input logic [7:0] c);
        case (c)
            "G": return int'(W_G);
            "M": return int'(W_M);
            "X": return int'(W_X);
            "Y": return int'(W_Y);
            "Z": return int'(W_Z);
            "E": return int'(W_E);
            "F": return int'(W_F);
            "S": return int'(W_S);
            "P": return int'(W_P);
            "T": return int'(W_T);
            "N": return int'(W_N);
            "*": return int'(W_CK);
            default: return -1;
        endcase
    endfunction

    function automatic void finish_word();
        case (open_letter)
            "G": cur_g = whole_part();
            "M": cur_m = whole_part();
            "X": cur_axis[0] = scaled(1000);
            "Y": cur_axis[1] = scaled(1000);
            "Z": cur_axis[2] = scaled(1000);
            "E": cur_axis[3] = scaled(1000);
            "F": cur_feed = scaled(1000);
            "S": begin
                if (cur_m == M_HOTEND_SET || cur_m == M_HOTEND_WAIT || cur_m == M_BED_SET)
                    cur_s = scaled(HEAT_FACTOR);
                else if (cur_m >= M_PID_LO && cur_m <= M_PID_HI)
                    cur_s = scaled(PID_FACTOR);
                else
                    cur_s = scaled(UNIT_FACTOR);
            end
            "P": cur_p = scaled(1);
            "T": cur_tool = whole_part();
            "N": cur_line = scaled(1);
            "*": rx_sum = scaled(1);
            default: ;
        endcase
        open_letter = 0;
        num_neg = 0;
        num_mant = 0;
        num_dec = 0;
    endfunction

    function automatic void reset_model();
        rel_xyz = 0; rel_e = 1;
        open_letter = 0; num_neg = 0; num_mant = 0; num_dec = 0;
        cur_g = 1; cur_m = 0; cur_tool = 0;
        for (int i = 0; i < 4; i++) cur_axis[i] = 0;
        cur_feed = 0; cur_s = 0; cur_p = 0; cur_line = 0; rx_sum = 0;
        calc_sum = 0; seen = 12'h001; in_semi = 0; in_paren = 0;
    endfunction

    // returns 1 when the character ends a line, with the command in cmd
    function automatic bit parse_char(input logic [7:0] raw, output out_t cmd);
        logic [7:0] c;
        bit letter, eol;
        int b;
        c = raw;
        if (c >= "a" && c <= "z") c = c - 8'd32;
        letter = (c >= "A" && c <= "Z");
        eol = (c == 8'd10 || c == 8'd13);
        cmd = '0;
        if (open_letter != 0 && (letter || c == "*" || eol)) finish_word();
        if (!in_semi && !in_paren) begin
            if (letter || c == "*") open_letter = c;
            b = letter_index(c);
            if (b >= 0) begin
                seen[b] = 1'b1;
                if (c == "G") seen[W_M] = 1'b0;
                else if (c == "M") seen[W_G] = 1'b0;
            end else if (c == ";") begin
                in_semi = 1;
            end else if (c == "(") begin
                in_paren = 1;
            end else if (c == "-") begin
                num_neg = 1; num_mant = 0; num_dec = 0;
            end else if (c == ".") begin
                if (num_dec == 0) num_dec = 1;
            end else if (c >= "0" && c <= "9") begin
                if (num_dec < MAX_DECIMALS + 1 && num_mant < MANTISSA_LIMIT) begin
                    num_mant = num_mant * 10 + (c - "0");
                    if (num_dec != 0) num_dec = num_dec + 1;
                end
            end
        end else if (in_paren && c == ")") begin
            in_paren = 0;
        end
        if (!seen[CK_BIT]) calc_sum = calc_sum ^ raw;
        if (!eol) return 0;
        cmd.seen_mask = {seen[CK_BIT] && rx_sum != {24'd0, calc_sum}, seen};
        cmd.g_number = cur_g; cmd.m_number = cur_m;
        cmd.pos_x = cur_axis[0]; cmd.pos_y = cur_axis[1];
        cmd.pos_z = cur_axis[2]; cmd.pos_e = cur_axis[3];
        cmd.feed_rate = cur_feed; cmd.s_value = cur_s; cmd.p_value = cur_p;
        cmd.tool_number = cur_tool; cmd.line_number = cur_line;
        seen = 12'h001; cur_g = 1; in_semi = 0; in_paren = 0;
        rx_sum = 0; calc_sum = 0;
        if (rel_xyz) begin
            cur_axis[0] = 0; cur_axis[1] = 0; cur_axis[2] = 0;
        end
        if (rel_xyz || rel_e) cur_axis[3] = 0;
        return 1;
    endfunction

    task automatic report(input string what, input logic [31:0] g, input logic [31:0] e);
        $display("%0t: %s got %h want %h", $realtime, what, g, e);
        errors++;
    endtask

    // apb write, register taken on the access cycle
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_REL_XYZ) rel_xyz = data[0];
        else rel_e = data[0];
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    // typed rows override mask and g number with hand-read values
    task automatic send_char(input logic [7:0] c, input bit typed,
                             input logic [12:0] t_mask, input logic [7:0] t_g);
        out_t cmd;
        bit ok;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= c;
        do begin
            @(negedge aclk);
            ok = s_ready;
            @(posedge aclk);
        end while (!ok);
        sent++;
        if (parse_char(c, cmd)) begin
            if (typed) begin
                cmd.seen_mask = t_mask;
                cmd.g_number = t_g;
            end
            pending_cmds.push_back(cmd);
        end
    endtask

    task automatic send_text(input string s, input bit typed,
                             input logic [12:0] t_mask, input logic [7:0] t_g);
        for (int i = 0; i < s.len(); i++) send_char(s[i], typed, t_mask, t_g);
    endtask

    function automatic logic [7:0] rand_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z" && $urandom_range(0, 3) == 0) return c + 8'd32;
        return c;
    endfunction

    function automatic string number_text();
        string s;
        int nd;
        s = "";
        if ($urandom_range(0, 2) == 0) s = "-";
        nd = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 10) : $urandom_range(0, 4);
        for (int i = 0; i < nd; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        if ($urandom_range(0, 1)) begin
            s = {s, "."};
            nd = $urandom_range(0, 5);
            for (int i = 0; i < nd; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
            if ($urandom_range(0, 15) == 0) s = {s, "."};
        end
        return s;
    endfunction

    function automatic string random_line();
        string s, w;
        string letters;
        logic [7:0] x;
        int n;
        letters = "GMXYZEFSPTN";
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 8);
            s = "";
            for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(0, 255)))};
        end else begin
            s = "";
            if ($urandom_range(0, 3) == 0) s = {"N", number_text(), " "};
            if ($urandom_range(0, 1)) begin
                w = $urandom_range(0, 1) ? "M" : "G";
                s = {s, w};
                case ($urandom_range(0, 3))
                    0: s = {s, $sformatf("%0d", 104 + 5 * $urandom_range(0, 1))};
                    1: s = {s, $sformatf("%0d", $urandom_range(130, 132))};
                    2: s = {s, "140"};
                    default: s = {s, number_text()};
                endcase
            end
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                s = {s, string'(letters[$urandom_range(0, 10)]), number_text(),
                     $urandom_range(0, 1) ? " " : ""};
            case ($urandom_range(0, 7))
                0: s = {s, ";c", string'(letters[$urandom_range(0, 10)]), "9"};
                1: s = {s, "(x1 ", string'(letters[$urandom_range(0, 10)]), ")Y2"};
                default: ;
            endcase
            for (int i = 0; i < s.len(); i++) s[i] = rand_case(s[i]);
            if ($urandom_range(0, 2) == 0) begin
                x = 0;
                for (int i = 0; i < s.len(); i++) x ^= s[i];
                if ($urandom_range(0, 3) == 0) x = x + $urandom_range(1, 255);
                s = {s, "*", $sformatf("%0d", x)};
            end
        end
        case ($urandom_range(0, 3))
            0: s = {s, "\r"};
            1: s = {s, "\r\n"};
            default: s = {s, "\n"};
        endcase
        return s;
    endfunction

    typedef struct {
        string       text;
        bit          typed;
        logic [12:0] mask;
        logic [7:0]  g;
    } row_t;

    row_t directed[$] = '{
        '{"\n", 1'b1, 13'h0001, 8'd1},
        '{"m104s9.5\r", 1'b0, '0, '0},
        '{"*0\n", 1'b1, 13'h0801, 8'd1},
        '{"*7\n", 1'b1, 13'h1801, 8'd1},
        '{"x9999999\n", 1'b0, '0, '0},
        '{"E-0.0005\n", 1'b0, '0, '0}
    };

    // receiver side, with random stalls and one long hold-off
    initial begin
        int n;
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (STALL_LEN) @(posedge aclk);
                long_hold = 0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(negedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                report("unexpected item", got.seen_mask, 0);
            end else begin
                want = pending_cmds.pop_front();
                if (got.seen_mask !== want.seen_mask) report("seen_mask", got.seen_mask, want.seen_mask);
                if (got.g_number !== want.g_number) report("g_number", got.g_number, want.g_number);
                if (got.m_number !== want.m_number) report("m_number", got.m_number, want.m_number);
                if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
                if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
                if (got.pos_z !== want.pos_z) report("pos_z", got.pos_z, want.pos_z);
                if (got.pos_e !== want.pos_e) report("pos_e", got.pos_e, want.pos_e);
                if (got.feed_rate !== want.feed_rate) report("feed_rate", got.feed_rate, want.feed_rate);
                if (got.s_value !== want.s_value) report("s_value", got.s_value, want.s_value);
                if (got.p_value !== want.p_value) report("p_value", got.p_value, want.p_value);
                if (got.tool_number !== want.tool_number)
                    report("tool_number", got.tool_number, want.tool_number);
                if (got.line_number !== want.line_number)
                    report("line_number", got.line_number, want.line_number);
            end
        end
        if (aresetn && !(s_valid && s_ready) && !(m_valid && m_ready)) idle_cycles++;
        else idle_cycles = 0;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int phase;
        reset_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i])
            send_text(directed[i].text, directed[i].typed, directed[i].mask, directed[i].g);
        wait_drained();
        phase = 0;
        while (sent < ITEM_GOAL) begin
            if (sent >= phase * 400 + 100) begin
                wait_drained();
                write_reg(ADDR_REL_XYZ, {31'd0, phase[0]});
                write_reg(ADDR_REL_E, {31'd0, phase[1]});
                if (phase == 1) long_hold = 1;
                phase++;
            end
            if (sent > ITEM_GOAL - 250) quiet = 1;
            send_text(random_line(), 1'b0, '0, '0);
        end
        wait_drained();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gclp_pkg.sv
src/gclp_parse.sv
src/gclp_scale.sv
src/gclp_hold.sv
src/gcode_line_parser_top.sv
tb/sv/gcode_line_parser_top_tb.sv
